/* sv/kvlp_pkg.sv */
// Shared types, constants and character class helpers for the key/value line parser.
// Used by the parser top level and its port checker; depends on nothing.
`default_nettype none

package kvlp_pkg;

  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int RESULT_CAP = 32;
  localparam int RES_CNT_W  = $clog2(RESULT_CAP);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DIG_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIG_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDING       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_SPACES  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_SPECIAL = 8'd3;

  // Register reset values
  localparam logic [CHAR_W-1:0] DELIMITER_RESET = 8'd61;
  localparam logic [CHAR_W-1:0] ENDING_RESET    = 8'd10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FLT_RD,
    ST_FLT_EV,
    ST_BOUNDS,
    ST_SCN_RD,
    ST_SCN_EV,
    ST_CALC,
    ST_TRM_RD,
    ST_TRM_EV,
    ST_CHK,
    ST_EMT_RD,
    ST_EMT_LD,
    ST_FINISH
  } state_t;

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return (c >= CH_DIG_0 && c <= CH_DIG_9) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_end(input logic [CHAR_W-1:0] c,
                                  input logic [CHAR_W-1:0] ending);
    return (c == ending) || (c == CH_LF) || (c == CH_CR) || (c == CH_NUL);
  endfunction

  // Survives the special character filter
  function automatic logic keep_special(input logic [CHAR_W-1:0] c,
                                        input logic [CHAR_W-1:0] delim,
                                        input logic [CHAR_W-1:0] ending,
                                        input logic              drop_special);
    return !(drop_special && !is_alnum(c) && (c != delim) && !is_end(c, ending));
  endfunction

endpackage

`default_nettype wire

/* sv/kvlp_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Used for the line buffers of the key/value line parser; no dependencies.
`default_nettype none

module kvlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/key_value_line_parser_top.sv */
// Key/value line parser: collects characters into a line buffer and, at a line end,
// splits the line at its delimiter and sends out the trimmed name and value characters.
// Depends on kvlp_pkg and kvlp_ram.
// Ordinary characters: accepted and stored, ready again the next cycle.
// Line end: a filter copy of the stored characters, then two scan passes over the trimmed
// line (delimiter search, whitespace trim), then the results, each of which may wait on
// an output stall; every pass reads one line buffer entry per step through its read port.
// Results leave through an output register; the last one may wait while input resumes.
// Reset (rst, synchronous): line length zero, configuration registers to defaults; buffers undefined.
`default_nettype none

module key_value_line_parser_top #(
  parameter int LINE_MAX = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [kvlp_pkg::CHAR_W-1:0]     in_char,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [kvlp_pkg::CHAR_W-1:0]     out_char,
  output logic                                 is_value_part,
  output logic                                 last_of_pair,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [kvlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kvlp_pkg::CHAR_W-1:0]     cfg_data
);

  localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int CW = $clog2(LINE_MAX + 1);
  localparam int KW = kvlp_pkg::RES_CNT_W;
  localparam logic [CW-1:0] LEN_MAX = CW'(LINE_MAX);
  localparam logic [KW-1:0] K_LAST  = KW'(kvlp_pkg::RESULT_CAP - 1);

  // Configuration registers
  logic [kvlp_pkg::CHAR_W-1:0] delimiter_char;
  logic [kvlp_pkg::CHAR_W-1:0] ending_char;
  logic                        drop_spaces;
  logic                        drop_special;

  // Control state
  kvlp_pkg::state_t state, state_next;
  logic [CW-1:0]    len, len_next;
  logic             out_valid_next;

  // Datapath registers
  logic [CW-1:0] len_proc, len_proc_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] n, n_next;
  logic          have_nw, have_nw_next;
  logic [CW-1:0] fnw, fnw_next;
  logic [CW-1:0] lnw1, lnw1_next;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] pd, pd_next;
  logic          pd_found, pd_found_next;
  logic [CW-1:0] pe, pe_next;
  logic          pe_found, pe_found_next;
  logic [CW-1:0] va_lo, va_lo_next;
  logic [CW-1:0] va_hi, va_hi_next;
  logic          nm_any, nm_any_next;
  logic [CW-1:0] nm_f, nm_f_next;
  logic [CW-1:0] nm_l1, nm_l1_next;
  logic          va_any, va_any_next;
  logic [CW-1:0] va_f, va_f_next;
  logic [CW-1:0] va_l1, va_l1_next;
  logic          part, part_next;
  logic [KW-1:0] k, k_next;
  logic [kvlp_pkg::CHAR_W-1:0] out_char_next;
  logic          is_value_part_next;
  logic          last_of_pair_next;

  // Line buffer ports
  logic                        store_we;
  logic [AW-1:0]               store_waddr;
  logic [AW-1:0]               store_raddr;
  logic [kvlp_pkg::CHAR_W-1:0] store_rdata;
  logic                        t_we;
  logic [AW-1:0]               t_waddr;
  logic [kvlp_pkg::CHAR_W-1:0] t_wdata;
  logic [AW-1:0]               t_raddr;
  logic [kvlp_pkg::CHAR_W-1:0] t_rdata;

  // Line as received, less the characters that the input filter drops
  kvlp_ram #(.WIDTH(kvlp_pkg::CHAR_W), .DEPTH(LINE_MAX)) u_line_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (in_char),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // Filtered copy of the line
  kvlp_ram #(.WIDTH(kvlp_pkg::CHAR_W), .DEPTH(LINE_MAX)) u_filt_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char <= kvlp_pkg::DELIMITER_RESET;
      ending_char    <= kvlp_pkg::ENDING_RESET;
      drop_spaces    <= 1'b0;
      drop_special   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kvlp_pkg::CFG_DELIMITER:    delimiter_char <= cfg_data;
        kvlp_pkg::CFG_ENDING:       ending_char    <= cfg_data;
        kvlp_pkg::CFG_DROP_SPACES:  drop_spaces    <= cfg_data[0];
        kvlp_pkg::CFG_DROP_SPECIAL: drop_special   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // State register and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kvlp_pkg::ST_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      out_valid <= out_valid_next;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    len_proc      <= len_proc_next;
    i             <= i_next;
    n             <= n_next;
    have_nw       <= have_nw_next;
    fnw           <= fnw_next;
    lnw1          <= lnw1_next;
    lo            <= lo_next;
    hi            <= hi_next;
    j             <= j_next;
    pd            <= pd_next;
    pd_found      <= pd_found_next;
    pe            <= pe_next;
    pe_found      <= pe_found_next;
    va_lo         <= va_lo_next;
    va_hi         <= va_hi_next;
    nm_any        <= nm_any_next;
    nm_f          <= nm_f_next;
    nm_l1         <= nm_l1_next;
    va_any        <= va_any_next;
    va_f          <= va_f_next;
    va_l1         <= va_l1_next;
    part          <= part_next;
    k             <= k_next;
    out_char      <= out_char_next;
    is_value_part <= is_value_part_next;
    last_of_pair  <= last_of_pair_next;
  end

  // Sequencer: next state, datapath and buffer controls
  always_comb begin
    logic [CW-1:0] len_eff;
    logic          in_end;
    logic          in_keep;
    logic [CW-1:0] lo_v;
    logic [CW-1:0] hi_v;
    logic [CW-1:0] a_v;
    logic [CW-1:0] b_v;
    logic          last_v;

    state_next         = state;
    len_next           = len;
    out_valid_next     = out_valid && !out_ready;
    len_proc_next      = len_proc;
    i_next             = i;
    n_next             = n;
    have_nw_next       = have_nw;
    fnw_next           = fnw;
    lnw1_next          = lnw1;
    lo_next            = lo;
    hi_next            = hi;
    j_next             = j;
    pd_next            = pd;
    pd_found_next      = pd_found;
    pe_next            = pe;
    pe_found_next      = pe_found;
    va_lo_next         = va_lo;
    va_hi_next         = va_hi;
    nm_any_next        = nm_any;
    nm_f_next          = nm_f;
    nm_l1_next         = nm_l1;
    va_any_next        = va_any;
    va_f_next          = va_f;
    va_l1_next         = va_l1;
    part_next          = part;
    k_next             = k;
    out_char_next      = out_char;
    is_value_part_next = is_value_part;
    last_of_pair_next  = last_of_pair;

    in_ready    = 1'b0;
    store_we    = 1'b0;
    store_waddr = '0;
    store_raddr = i[AW-1:0];
    t_we        = 1'b0;
    t_waddr     = n[AW-1:0];
    t_wdata     = store_rdata;
    t_raddr     = j[AW-1:0];

    len_eff = (len >= LEN_MAX) ? '0 : len;
    in_end  = kvlp_pkg::is_end(in_char, ending_char);
    in_keep = kvlp_pkg::keep_special(in_char, delimiter_char, ending_char, drop_special) &&
              !(drop_spaces && (in_char == kvlp_pkg::CH_SPACE));
    lo_v    = '0;
    hi_v    = '0;
    a_v     = '0;
    b_v     = '0;
    last_v  = 1'b0;

    unique case (state)
      // Take characters; a full buffer restarts before the character is handled
      kvlp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_keep) begin
            len_next = len_eff;
          end else if (!in_end) begin
            store_we    = 1'b1;
            store_waddr = len_eff[AW-1:0];
            len_next    = len_eff + CW'(1);
          end else begin
            len_proc_next = len_eff;
            i_next        = '0;
            n_next        = '0;
            have_nw_next  = 1'b0;
            state_next    = (len_eff == '0) ? kvlp_pkg::ST_BOUNDS : kvlp_pkg::ST_FLT_RD;
          end
        end
      end

      kvlp_pkg::ST_FLT_RD: begin
        state_next = kvlp_pkg::ST_FLT_EV;
      end

      // Filter copy, noting first and last non-whitespace position
      kvlp_pkg::ST_FLT_EV: begin
        if (kvlp_pkg::keep_special(store_rdata, delimiter_char, ending_char, drop_special)) begin
          t_we   = 1'b1;
          n_next = n + CW'(1);
          if (!kvlp_pkg::is_ws(store_rdata)) begin
            if (!have_nw) begin
              fnw_next = n;
            end
            have_nw_next = 1'b1;
            lnw1_next    = n + CW'(1);
          end
        end
        i_next     = i + CW'(1);
        state_next = (i + CW'(1) == len_proc) ? kvlp_pkg::ST_BOUNDS : kvlp_pkg::ST_FLT_RD;
      end

      // Line bounds, trimmed as a whole when spaces are dropped
      kvlp_pkg::ST_BOUNDS: begin
        if (drop_spaces) begin
          lo_v = have_nw ? fnw  : n;
          hi_v = have_nw ? lnw1 : n;
        end else begin
          lo_v = '0;
          hi_v = n;
        end
        lo_next       = lo_v;
        hi_next       = hi_v;
        j_next        = lo_v;
        pd_found_next = 1'b0;
        pe_found_next = 1'b0;
        state_next    = (lo_v < hi_v) ? kvlp_pkg::ST_SCN_RD : kvlp_pkg::ST_FINISH;
      end

      kvlp_pkg::ST_SCN_RD: begin
        state_next = kvlp_pkg::ST_SCN_EV;
      end

      // Search for first delimiter and first ending character
      kvlp_pkg::ST_SCN_EV: begin
        if (!pd_found && (t_rdata == delimiter_char)) begin
          pd_next       = j;
          pd_found_next = 1'b1;
        end
        if (!pe_found && (t_rdata == ending_char)) begin
          pe_next       = j;
          pe_found_next = 1'b1;
        end
        j_next     = j + CW'(1);
        state_next = (j + CW'(1) == hi) ? kvlp_pkg::ST_CALC : kvlp_pkg::ST_SCN_RD;
      end

      // Name and value spans before trimming
      kvlp_pkg::ST_CALC: begin
        a_v = pd + CW'(1);
        b_v = hi;
        if (pe_found && ((pe - lo) > CW'(2))) begin
          if (a_v > pe) begin
            b_v = a_v;
            a_v = pe;
          end else begin
            b_v = pe;
          end
        end
        va_lo_next  = a_v;
        va_hi_next  = b_v;
        nm_any_next = 1'b0;
        va_any_next = 1'b0;
        j_next      = lo;
        if (!pd_found || (pd == lo)) begin
          state_next = kvlp_pkg::ST_FINISH;
        end else begin
          state_next = kvlp_pkg::ST_TRM_RD;
        end
      end

      kvlp_pkg::ST_TRM_RD: begin
        state_next = kvlp_pkg::ST_TRM_EV;
      end

      // Whitespace trim of both spans in one sweep
      kvlp_pkg::ST_TRM_EV: begin
        if (!kvlp_pkg::is_ws(t_rdata)) begin
          if ((j >= lo) && (j < pd)) begin
            if (!nm_any) begin
              nm_f_next = j;
            end
            nm_any_next = 1'b1;
            nm_l1_next  = j + CW'(1);
          end
          if ((j >= va_lo) && (j < va_hi)) begin
            if (!va_any) begin
              va_f_next = j;
            end
            va_any_next = 1'b1;
            va_l1_next  = j + CW'(1);
          end
        end
        j_next     = j + CW'(1);
        state_next = (j + CW'(1) == hi) ? kvlp_pkg::ST_CHK : kvlp_pkg::ST_TRM_RD;
      end

      kvlp_pkg::ST_CHK: begin
        j_next    = nm_f;
        part_next = 1'b0;
        k_next    = '0;
        state_next = (nm_any && va_any) ? kvlp_pkg::ST_EMT_RD : kvlp_pkg::ST_FINISH;
      end

      kvlp_pkg::ST_EMT_RD: begin
        state_next = kvlp_pkg::ST_EMT_LD;
      end

      // Load output register once free; cap on result count
      kvlp_pkg::ST_EMT_LD: begin
        if (!out_valid || out_ready) begin
          last_v = (part && (j + CW'(1) == va_l1)) || (k == K_LAST);
          out_valid_next     = 1'b1;
          out_char_next      = t_rdata;
          is_value_part_next = part;
          last_of_pair_next  = last_v;
          k_next             = k + KW'(1);
          if (last_v) begin
            state_next = kvlp_pkg::ST_FINISH;
          end else begin
            if (!part && (j + CW'(1) == nm_l1)) begin
              part_next = 1'b1;
              j_next    = va_f;
            end else begin
              j_next    = j + CW'(1);
            end
            state_next = kvlp_pkg::ST_EMT_RD;
          end
        end
      end

      // Line consumed, line length cleared
      kvlp_pkg::ST_FINISH: begin
        len_next   = '0;
        state_next = kvlp_pkg::ST_IDLE;
      end

      default: begin
        state_next = kvlp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/kvlp_checker.sv */
// Port level checker for the key/value line parser, bound to the top level below.
// Depends on kvlp_pkg; sees the top level's ports only.
`default_nettype none

module kvlp_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic [kvlp_pkg::CHAR_W-1:0]    in_char,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [kvlp_pkg::CHAR_W-1:0]    out_char,
  input wire logic                           is_value_part,
  input wire logic                           last_of_pair,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [kvlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [kvlp_pkg::CHAR_W-1:0]    cfg_data
);

  // Shadow of the extra line end character, tracked from config writes
  logic [kvlp_pkg::CHAR_W-1:0] end_char_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_char_seen <= kvlp_pkg::ENDING_RESET;
    end else if (cfg_valid && cfg_ready && (cfg_index == kvlp_pkg::CFG_ENDING)) begin
      end_char_seen <= cfg_data;
    end
  end

  // A character that is no line end never holds off the next item
  a_plain_char_keeps_ready: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !kvlp_pkg::is_end(in_char, end_char_seen)) |=> in_ready)
    else $error("input stalled after a plain character");

  // LF always ends a line and starts the line pass
  a_lf_starts_pass: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_char == kvlp_pkg::CH_LF)) |=> !in_ready)
    else $error("input still ready after a line end");

  // Results appear only while a line pass is running
  a_result_in_pass: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready)
    else $error("result started while the input side was idle");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_char) && $stable(is_value_part) && $stable(last_of_pair)))
    else $error("stalled result changed");

endmodule

bind key_value_line_parser_top kvlp_checker u_kvlp_checker (.*);

`default_nettype wire
